// ----- rtl/fmrp_pkg.sv -----
// Shared constants and types for the four-channel motor ramp / PWM shaper.
// No dependencies; imported by every module of the block.
`default_nettype none

package fmrp_pkg;

    localparam int CHANNELS      = 4;
    localparam int FRAC_BITS_DEF = 8;
    localparam int CMD_W         = 8;
    localparam int SCALE_W       = 7;
    localparam int STEPS_W       = 7;
    localparam int DIVISOR_W     = 7;
    localparam int PROD_W        = CMD_W + SCALE_W;
    localparam int LEVEL_W       = 24;
    localparam int VAL_W         = LEVEL_W + 1;
    localparam int DUTY_W        = 8;
    localparam int IP_W          = 7;
    localparam int MAX_STEPS     = 64;
    localparam int K_W           = $clog2(MAX_STEPS);
    localparam int CH_W          = $clog2(CHANNELS);

    localparam logic [STEPS_W-1:0]   STEPS_RESET    = 7'd10;
    localparam logic [STEPS_W-1:0]   STEPS_MAX      = 7'd64;
    localparam logic [DIVISOR_W-1:0] DIRECT_DIVISOR = 7'd100;

    // duty = ip * 255 / 100 == (ip * DUTY_RECIP) >> DUTY_SHIFT for ip <= 100
    localparam int                   DUTY_SHIFT = 19;
    localparam logic [20:0]          DUTY_RECIP = 21'd1336965;

    // stream packing
    localparam int S_TDATA_W = 40;
    localparam int M_FIELD_W = CHANNELS * (1 + DUTY_W);
    localparam int M_TDATA_W = 40;

    typedef enum logic {
        FUNC_DIRECT = 1'b0,
        FUNC_RAMP   = 1'b1
    } func_t;

    typedef struct packed {
        logic              dir;
        logic [DUTY_W-1:0] duty;
    } chan_out_t;

endpackage

`default_nettype wire

// ----- rtl/fmrp_div.sv -----
// Shared restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on fmrp_pkg for the divisor width.
`default_nettype none

module fmrp_div #(
    parameter int DW = 25
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire logic [DW-1:0]                  dividend,
    input  wire logic [fmrp_pkg::DIVISOR_W-1:0] divisor,
    output logic                                done,
    output logic [DW-1:0]                       quotient
);
    import fmrp_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dsr_reg;
    logic [DW-1:0]        quo_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[DW-1]};
        fits    = (shifted >= {1'b0, dsr_reg});
        diff    = shifted - {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dsr_reg  <= divisor;
                cnt_reg  <= CW'(DW);
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end else if (busy_reg) begin
                rem_reg  <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
                quo_reg  <= {quo_reg[DW-2:0], fits};
                cnt_reg  <= cnt_reg - CW'(1);
                done_reg <= (cnt_reg == CW'(1));
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/fmrp_shape.sv -----
// Per-channel output shaping: clamp, dead band, minimum drive, sign and duty.
// Depends on fmrp_pkg for widths and the duty reciprocal.
`default_nettype none

module fmrp_shape #(
    parameter int FRAC_BITS = fmrp_pkg::FRAC_BITS_DEF
) (
    input  wire logic signed [fmrp_pkg::VAL_W-1:0] val,
    output fmrp_pkg::chan_out_t                    chan_out
);
    import fmrp_pkg::*;

    localparam logic signed [VAL_W-1:0] ONE    = VAL_W'(1) << FRAC_BITS;
    localparam logic signed [VAL_W-1:0] TEN    = VAL_W'(10) << FRAC_BITS;
    localparam logic signed [VAL_W-1:0] HI     = VAL_W'(100) << FRAC_BITS;
    localparam logic signed [VAL_W-1:0] NEG_HI = -HI;

    logic signed [VAL_W-1:0] vc;
    logic [VAL_W-1:0]        a;
    logic [VAL_W-1:0]        mag;
    logic [IP_W-1:0]         ip;
    logic [IP_W+20:0]        prod;

    always_comb begin
        if (val > HI) begin
            vc = HI;
        end else if (val < NEG_HI) begin
            vc = NEG_HI;
        end else begin
            vc = val;
        end
        a = vc[VAL_W-1] ? VAL_W'(-vc) : VAL_W'(vc);
        // dead band up to and including one unit, minimum drive of ten units above it
        if (a <= ONE) begin
            mag = '0;
        end else if (a < TEN) begin
            mag = TEN;
        end else begin
            mag = a;
        end
        ip   = mag[FRAC_BITS +: IP_W];
        prod = (IP_W + 21)'(ip) * (IP_W + 21)'(DUTY_RECIP);
        chan_out.dir  = vc[VAL_W-1] && (a > ONE);
        chan_out.duty = prod[DUTY_SHIFT +: DUTY_W];
    end

endmodule

`default_nettype wire

// ----- rtl/four_motor_ramp_pwm_shaper.sv -----
// Four-channel motor command shaper: top level with sequencer and level store.
// Depends on fmrp_pkg, fmrp_div and fmrp_shape.
//
// Usage:
//   s_ channel: one transfer carries four signed percent commands and a scale
//   (tdata) and the function in tuser: direct (one result) or ramp.
//   m_ channel: each result carries four direction bits and four 8-bit duties;
//   tlast marks the final result of an input transfer.
//   cfg_we / cfg_wdata write ramp_steps (reset 10; 0 acts as 1, above 64 as 64).
//   Write it only while the block is idle.
// Sequencing: per result the sequencer walks the four channels through the one
// shared multiplier and the one shared bit-serial divider, whose width is
// DW = max(14 + FRAC_BITS, 25). A direct transfer gives one result; a ramp
// transfer gives ramp_steps results (as clamped above), one per step.
// s_tready is high only between items.
// Stall: while a result sits in the output register the next one is computed
// and held in ST_EMIT until m_tready frees the register. A new input transfer
// is still taken while the last result of the previous one waits.
// Reset: channel levels clear to zero, ramp_steps returns to 10, outputs idle.
`default_nettype none

module four_motor_ramp_pwm_shaper #(
    parameter int FRAC_BITS = fmrp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic [fmrp_pkg::STEPS_W-1:0]       cfg_wdata,   // ramp_steps
    // command stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // cmd_a[7:0] cmd_b[15:8] cmd_c[23:16] cmd_d[31:24] scale_pct[38:32]
    input  wire logic [fmrp_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                               s_tuser,     // func
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // dir_a[0] dir_b[1] dir_c[2] dir_d[3] duty_a[11:4] duty_b[19:12]
    // duty_c[27:20] duty_d[35:28]
    output logic [fmrp_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                    m_tlast
);
    import fmrp_pkg::*;

    localparam int DW = (14 + FRAC_BITS > 25) ? (14 + FRAC_BITS) : 25;
    localparam int XW = DW + 2;

    localparam logic signed [XW-1:0] LVL_MAX_X = XW'((64'sd1 <<< (LEVEL_W - 1)) - 64'sd1);
    localparam logic signed [XW-1:0] LVL_MIN_X = -LVL_MAX_X - XW'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_WAIT,
        ST_EMIT
    } state_t;

    function automatic logic signed [LEVEL_W-1:0] sat_level(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        r = v;
        if (v > LVL_MAX_X) r = LVL_MAX_X;
        if (v < LVL_MIN_X) r = LVL_MIN_X;
        return LEVEL_W'(r);
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t                     state_reg;
    logic [STEPS_W-1:0]         ramp_steps_reg;
    func_t                      func_reg;
    logic signed [CMD_W-1:0]    cmd_reg   [CHANNELS];
    logic [SCALE_W-1:0]         scale_reg;
    logic [STEPS_W-1:0]         steps_reg;
    logic [CH_W-1:0]            ch_reg;
    logic [K_W-1:0]             k_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [LEVEL_W-1:0]  level_reg [CHANNELS];
    logic signed [VAL_W-1:0]    val_reg   [CHANNELS];
    logic                       div_start_reg;
    logic [DW-1:0]              div_dividend_reg;
    logic [DIVISOR_W-1:0]       div_divisor_reg;
    logic                       neg_reg;
    logic                       m_tvalid_reg;
    logic                       m_tlast_reg;
    logic [M_FIELD_W-1:0]       m_fields_reg;

    // ------------------------------------------------------------------
    // combinational datapath
    // ------------------------------------------------------------------
    logic signed [CMD_W-1:0]    cmd_in [CHANNELS];
    logic [SCALE_W-1:0]         scale_in;
    logic [STEPS_W-1:0]         steps_eff;
    logic signed [PROD_W-1:0]   prod_mul;
    logic [PROD_W-1:0]          prod_abs;
    logic signed [XW-1:0]       goal_x;
    logic signed [XW-1:0]       diff_x;
    logic [XW-1:0]              diff_abs;
    logic signed [XW-1:0]       quo_s;
    logic signed [LEVEL_W-1:0]  level_new;
    logic                       div_done;
    logic [DW-1:0]              div_quo;
    logic                       is_last;
    logic                       out_free;
    chan_out_t                  shp [CHANNELS];
    logic [M_FIELD_W-1:0]       fields_pk;

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            cmd_in[i] = s_tdata[i*CMD_W +: CMD_W];
        end
        scale_in = s_tdata[CHANNELS*CMD_W +: SCALE_W];

        if (ramp_steps_reg == '0) begin
            steps_eff = STEPS_W'(1);
        end else if (ramp_steps_reg > STEPS_MAX) begin
            steps_eff = STEPS_MAX;
        end else begin
            steps_eff = ramp_steps_reg;
        end

        // the one shared multiplier: command times scale for the current channel
        prod_mul = PROD_W'(cmd_reg[ch_reg]) * PROD_W'($signed({1'b0, scale_reg}));
        prod_abs = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

        // ramp: goal minus current level, divided by the step count
        goal_x   = XW'(sat_level(XW'(prod_reg) <<< FRAC_BITS));
        diff_x   = goal_x - XW'(level_reg[ch_reg]);
        diff_abs = diff_x[XW-1] ? XW'(-diff_x) : XW'(diff_x);

        // quotient back to signed, truncated toward zero
        quo_s     = neg_reg ? -$signed(XW'(div_quo)) : $signed(XW'(div_quo));
        level_new = sat_level(XW'(level_reg[ch_reg]) + quo_s);

        is_last  = (func_reg == FUNC_DIRECT) || ({1'b0, k_reg} == (steps_reg - STEPS_W'(1)));
        out_free = !m_tvalid_reg || m_tready;

        for (int i = 0; i < CHANNELS; i++) begin
            fields_pk[i] = shp[i].dir;
            fields_pk[CHANNELS + i*DUTY_W +: DUTY_W] = shp[i].duty;
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_shape
        fmrp_shape #(
            .FRAC_BITS (FRAC_BITS)
        ) u_shape (
            .val      (val_reg[g]),
            .chan_out (shp[g])
        );
    end

    fmrp_div #(
        .DW (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_dividend_reg),
        .divisor  (div_divisor_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ------------------------------------------------------------------
    // sequencer, level store and output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ramp_steps_reg <= STEPS_RESET;
            div_start_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                level_reg[i] <= '0;
            end
        end else begin
            // divider start is registered from the load state, so it rises in the cycle after its operands are loaded
            div_start_reg <= (state_reg == ST_LOAD);
            if (cfg_we) begin
                ramp_steps_reg <= cfg_wdata;
            end
            // output valid: set on emit, cleared once the receiver takes it
            if (state_reg == ST_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        func_reg  <= func_t'(s_tuser);
                        scale_reg <= scale_in;
                        steps_reg <= steps_eff;
                        ch_reg    <= '0;
                        k_reg     <= '0;
                        for (int i = 0; i < CHANNELS; i++) begin
                            cmd_reg[i] <= cmd_in[i];
                            // direct item stores the unscaled command as the level
                            if (func_t'(s_tuser) == FUNC_DIRECT) begin
                                level_reg[i] <= sat_level(XW'(cmd_in[i]) <<< FRAC_BITS);
                            end
                        end
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= prod_mul;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    if (func_reg == FUNC_DIRECT) begin
                        div_dividend_reg <= DW'(prod_abs) << FRAC_BITS;
                        div_divisor_reg  <= DIRECT_DIVISOR;
                        neg_reg          <= prod_reg[PROD_W-1];
                    end else begin
                        div_dividend_reg <= DW'(diff_abs);
                        div_divisor_reg  <= DIVISOR_W'(steps_reg);
                        neg_reg          <= diff_x[XW-1];
                    end
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (div_done) begin
                        if (func_reg == FUNC_DIRECT) begin
                            val_reg[ch_reg] <= VAL_W'(quo_s);
                        end else begin
                            level_reg[ch_reg] <= level_new;
                            val_reg[ch_reg]   <= VAL_W'(level_new);
                        end
                        if (ch_reg == CH_W'(CHANNELS - 1)) begin
                            state_reg <= ST_EMIT;
                        end else begin
                            ch_reg    <= ch_reg + CH_W'(1);
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_EMIT: begin
                    // hold here while the previous result is still unclaimed
                    if (out_free) begin
                        m_tlast_reg  <= is_last;
                        m_fields_reg <= fields_pk;
                        ch_reg       <= '0;
                        if (is_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + K_W'(1);
                            state_reg <= ST_MUL;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELD_W){1'b0}}, m_fields_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("block still ready after taking an item");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_WAIT))
        else $error("divider finished outside the wait state");

    a_steps_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (steps_reg >= STEPS_W'(1) && steps_reg <= STEPS_MAX))
        else $error("latched step count out of range");

    a_step_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && func_reg == FUNC_RAMP) |-> ({1'b0, k_reg} < steps_reg))
        else $error("ramp step index past the step count");

    a_emit_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free) |=> m_tvalid)
        else $error("result not presented after emit");

endmodule

`default_nettype wire

// ----- bench/four_motor_ramp_pwm_shaper_checker.sv -----
`timescale 1ns / 1ps
// Result checker for four_motor_ramp_pwm_shaper: watches config, command and result streams.
// Keeps its own copy of the motor levels and ramp_steps; depends on fmrp_pkg only.
module four_motor_ramp_pwm_shaper_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [fmrp_pkg::STEPS_W-1:0]   cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [fmrp_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [fmrp_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    output int                             mismatches,
    output int                             frames_due
);
    import fmrp_pkg::*;

    localparam longint ONE_Q      = longint'(1) << FRAC_BITS_DEF;
    localparam longint LEVEL_TOP  = (longint'(1) << (LEVEL_W - 1)) - 1;
    localparam longint LEVEL_BOT  = -(longint'(1) << (LEVEL_W - 1));
    localparam longint PCT_FULL   = 100;
    localparam longint MIN_SPEED  = 10;
    localparam longint DUTY_FULL  = 255;

    typedef struct packed {
        logic [CHANNELS-1:0]             dir;
        logic [CHANNELS-1:0][DUTY_W-1:0] duty;
        logic                            last;
    } pwm_frame_t;

    pwm_frame_t         pwm_frames_q[$];
    longint             motor_level [CHANNELS];
    logic [STEPS_W-1:0] ramp_steps;
    int                 miss_count = 0;
    int                 due_count  = 0;
    string              motor_tag  = "abcd";

    assign mismatches = miss_count;
    assign frames_due = due_count;

    function automatic longint clip_level(input longint v);
        if (v > LEVEL_TOP) return LEVEL_TOP;
        if (v < LEVEL_BOT) return LEVEL_BOT;
        return v;
    endfunction

    // clamp, dead band and minimum-speed kick, then direction and duty
    function automatic void shape_speed(input longint v, output logic neg,
                                        output logic [DUTY_W-1:0] duty);
        longint mag;
        if (v > PCT_FULL * ONE_Q)  v = PCT_FULL * ONE_Q;
        if (v < -PCT_FULL * ONE_Q) v = -PCT_FULL * ONE_Q;
        if (v < -ONE_Q && v > -MIN_SPEED * ONE_Q) v = -MIN_SPEED * ONE_Q;
        if (v > ONE_Q && v < MIN_SPEED * ONE_Q)   v = MIN_SPEED * ONE_Q;
        if (v <= ONE_Q && v >= -ONE_Q)            v = 0;
        neg  = v < 0;
        mag  = (v < 0 ? -v : v) >> FRAC_BITS_DEF;
        duty = DUTY_W'(mag * DUTY_FULL / PCT_FULL);
    endfunction

    function automatic pwm_frame_t make_frame(input longint v [CHANNELS], input logic is_last);
        pwm_frame_t f;
        logic       neg;
        logic [DUTY_W-1:0] duty;
        int         i;
        for (i = 0; i < CHANNELS; i++) begin
            shape_speed(v[i], neg, duty);
            f.dir[i]  = neg;
            f.duty[i] = duty;
        end
        f.last = is_last;
        return f;
    endfunction

    task automatic plan_pwm_frames(input func_t fn, input logic [S_TDATA_W-1:0] word);
        longint cmd  [CHANNELS];
        longint goal [CHANNELS];
        longint vals [CHANNELS];
        longint scale;
        longint steps;
        int     i;
        int     k;
        scale = longint'(word[CHANNELS*CMD_W +: SCALE_W]);
        for (i = 0; i < CHANNELS; i++)
            cmd[i] = longint'($signed(word[CMD_W*i +: CMD_W]));
        if (fn == FUNC_DIRECT) begin
            for (i = 0; i < CHANNELS; i++) begin
                vals[i]        = (cmd[i] * scale * ONE_Q) / PCT_FULL;
                motor_level[i] = clip_level(cmd[i] * ONE_Q);
            end
            pwm_frames_q.push_back(make_frame(vals, 1'b1));
        end else begin
            steps = longint'(ramp_steps);
            if (steps < 1)         steps = 1;
            if (steps > MAX_STEPS) steps = MAX_STEPS;
            for (i = 0; i < CHANNELS; i++)
                goal[i] = clip_level(cmd[i] * scale * ONE_Q);
            for (k = 0; k < steps; k++) begin
                for (i = 0; i < CHANNELS; i++) begin
                    motor_level[i] = clip_level(motor_level[i]
                                                + (goal[i] - motor_level[i]) / steps);
                    vals[i] = motor_level[i];
                end
                pwm_frames_q.push_back(make_frame(vals, k == steps - 1));
            end
        end
    endtask

    task automatic check_pwm_frame();
        pwm_frame_t want;
        logic [DUTY_W-1:0] got_duty;
        int i;
        if (pwm_frames_q.size() == 0) begin
            $error("m_ transfer with no result due, tdata %h", m_tdata);
            miss_count++;
        end else begin
            want = pwm_frames_q.pop_front();
            for (i = 0; i < CHANNELS; i++) begin
                if (m_tdata[i] !== want.dir[i]) begin
                    $error("dir_%c: expected %0d, got %0d", motor_tag[i], want.dir[i], m_tdata[i]);
                    miss_count++;
                end
                got_duty = m_tdata[CHANNELS + DUTY_W*i +: DUTY_W];
                if (got_duty !== want.duty[i]) begin
                    $error("duty_%c: expected %0d, got %0d", motor_tag[i], want.duty[i], got_duty);
                    miss_count++;
                end
            end
            if (m_tlast !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, m_tlast);
                miss_count++;
            end
        end
    endtask

    // result popped before the new command is planned: a result never comes
    // from the command accepted at the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (motor_level[i]) motor_level[i] = 0;
            ramp_steps = STEPS_RESET;
            pwm_frames_q.delete();
        end else begin
            if (m_tvalid && m_tready) check_pwm_frame();
            if (cfg_we)               ramp_steps = cfg_wdata;
            if (s_tvalid && s_tready) plan_pwm_frames(func_t'(s_tuser), s_tdata);
        end
        due_count = pwm_frames_q.size();
    end

endmodule

// ----- bench/four_motor_ramp_pwm_shaper_tb.sv -----
`timescale 1ns / 1ps
// Top of the four_motor_ramp_pwm_shaper bench: clock, reset, command and config stimulus.
// Depends on fmrp_pkg, the block itself and four_motor_ramp_pwm_shaper_checker.
module four_motor_ramp_pwm_shaper_tb;
    import fmrp_pkg::*;

    // Hang limit for the whole run; it leaves plenty of room for the long
    // ramps and the random stalls.
    localparam int RUN_LIMIT     = 2_000_000;
    // settle wait after the final drain, longer than one result takes at Q8
    localparam int SETTLE_CYCLES = 200;
    localparam int MAX_WAIT      = 4;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [STEPS_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // cmd_a cmd_b cmd_c cmd_d scale_pct, low bits first
    logic                 s_tuser   = 1'b0;  // func
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // dir_a..dir_d, then duty_a..duty_d
    logic                 m_tlast;

    int mismatches;
    int frames_due;
    int cycle_count = 0;
    bit quiet_run   = 1'b0;  // both sides run without idle cycles while set

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    four_motor_ramp_pwm_shaper u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    four_motor_ramp_pwm_shaper_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .frames_due (frames_due)
    );

    // hang guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int draw_wait();
        return quiet_run ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_command(input logic [CMD_W-1:0] a, b, c, d,
                                                          input logic [SCALE_W-1:0] scale);
        return {1'b0, scale, d, c, b, a};
    endfunction

    // Commands: mostly the legal +-100 range, some around the dead band and
    // the minimum-speed kick, some anywhere in the 8-bit field.
    function automatic logic [CMD_W-1:0] pick_speed();
        case ($urandom_range(0, 9))
            0: return CMD_W'($urandom_range(0, 255));
            1: begin
                case ($urandom_range(0, 4))
                    0: return CMD_W'(100);
                    1: return CMD_W'(-100);
                    2: return CMD_W'(127);
                    3: return CMD_W'(-128);
                    default: return '0;
                endcase
            end
            2, 3: return CMD_W'(int'($urandom_range(0, 30)) - 15);
            default: return CMD_W'(int'($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    // Small scales keep ramp goals close to the shaping window, so the ramp
    // itself shows up in the duty; 101..127 covers the over-range scale.
    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return SCALE_W'(100);
            2: return SCALE_W'($urandom_range(101, 127));
            3, 4: return SCALE_W'($urandom_range(1, 3));
            default: return SCALE_W'($urandom_range(0, 100));
        endcase
    endfunction

    // Present one command at a falling edge, hold until the transfer.
    // tvalid stays up for back-to-back commands; it drops only for a gap.
    task automatic push_command(input func_t fn, input logic [S_TDATA_W-1:0] word);
        int gap;
        gap = draw_wait();
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic push_random_command();
        func_t fn;
        fn = ($urandom_range(0, 9) < 6) ? FUNC_RAMP : FUNC_DIRECT;
        push_command(fn, pack_command(pick_speed(), pick_speed(), pick_speed(), pick_speed(),
                                      pick_scale()));
    endtask

    // Stop sending and wait until every predicted result has been taken.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (frames_due != 0) @(negedge aclk);
    endtask

    // Register write only with the block idle.
    task automatic write_ramp_steps(input logic [STEPS_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stall before each transfer, tready then held high
    // until the transfer happens.
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = draw_wait();
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        // ramp_steps per phase: 0 and 65/127 hit the clamps to 1 and 64;
        // long-ramp phases get only a few commands
        int phase_steps [11];
        int phase_items [11];
        int p;

        phase_steps = '{1, 0, 3, 64, 2, 127, 7, 65, 10, 5, 16};
        phase_items = '{28, 25, 28, 4, 28, 3, 28, 4, 28, 28, 28};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, ramp_steps at its reset value of 10.
        // all zero
        push_command(FUNC_DIRECT, pack_command(8'd0, 8'd0, 8'd0, 8'd0, 7'd0));
        // full scale, clamp past +-100
        push_command(FUNC_DIRECT, pack_command(8'd100, -8'sd100, 8'd127, -8'sd128, 7'd100));
        // dead band at exactly one percent, kick up to ten below it
        push_command(FUNC_DIRECT, pack_command(8'd1, -8'sd1, 8'd5, -8'sd9, 7'd100));
        push_command(FUNC_DIRECT, pack_command(8'd2, -8'sd2, 8'd10, -8'sd10, 7'd100));
        // scale above 100
        push_command(FUNC_DIRECT, pack_command(8'd50, -8'sd50, 8'd3, -8'sd3, 7'd127));
        // tiny scaled values truncate toward zero
        push_command(FUNC_DIRECT, pack_command(8'd100, -8'sd100, 8'd99, -8'sd99, 7'd1));
        // ramps: from a stored direct level, to the largest goal, back to rest
        push_command(FUNC_RAMP, pack_command(8'd100, -8'sd100, 8'd50, -8'sd50, 7'd1));
        push_command(FUNC_RAMP, pack_command(8'd127, -8'sd128, 8'd100, -8'sd100, 7'd127));
        push_command(FUNC_RAMP, pack_command(8'd0, 8'd0, 8'd0, 8'd0, 7'd0));
        // second ramp to rest, from the levels the previous ramp left
        push_command(FUNC_RAMP, pack_command(8'd0, 8'd0, 8'd0, 8'd0, 7'd0));
        push_command(FUNC_DIRECT, pack_command(8'd60, -8'sd60, 8'd20, -8'sd20, 7'd50));
        push_command(FUNC_RAMP, pack_command(8'd4, -8'sd4, -8'sd1, 8'd1, 7'd3));
        push_command(FUNC_DIRECT, pack_command(8'd127, -8'sd128, 8'd1, -8'sd1, 7'd64));

        // Random phases; each starts from a drained block.
        for (p = 0; p < 11; p++) begin
            write_ramp_steps(STEPS_W'(phase_steps[p]));
            quiet_run = ($urandom_range(0, 3) == 0);
            repeat (phase_items[p]) push_random_command();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && frames_due == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/fmrp_pkg.sv
rtl/fmrp_div.sv
rtl/fmrp_shape.sv
rtl/four_motor_ramp_pwm_shaper.sv
bench/four_motor_ramp_pwm_shaper_checker.sv
bench/four_motor_ramp_pwm_shaper_tb.sv
